[hw/rtl/linear_probe_hash_insert_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash insert unit
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_INSERT_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_INSERT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lphi_pkg.sv]
// ----------------------------------------------------------------------------
// lphi_pkg
// Types and constants shared by the hash front end, job queue and probe engine.
// ----------------------------------------------------------------------------
package lphi_pkg;

    localparam int unsigned KEY_W      = 32;
    localparam int unsigned REF_W      = 16;
    localparam int unsigned OUT_SLOT_W = 7;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned SIZE_W     = 8;
    localparam int unsigned REM_W      = 34;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned DIGIT_W    = 4;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 8'd101;
    localparam logic [4:0]         HASH_OFFSET = 5'd13;
    localparam logic [STEP_W-1:0]  DIGIT_TOP   = 3'd3;
    localparam logic [STEP_W-1:0]  MOD_TOP     = 3'd4;

    localparam int unsigned CHUNK_BITS  = 32;
    localparam int unsigned CHUNK_SEL_W = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIGIT,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0] home;
        logic [REF_W-1:0]  rec_ref;
    } probe_job_t;

    typedef struct packed {
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] stored;
        logic              placed;
    } probe_result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Powers of ten for the decimal order of a 31-bit key.
    function automatic logic [REM_W-1:0] pow10(input logic [DIGIT_W-1:0] k);
        logic [REM_W-1:0] p;
        case (k)
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd1;
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/lphi_front.sv]
// ----------------------------------------------------------------------------
// lphi_front
// Takes keys, finds the leading decimal digit and reduces digit plus offset
// modulo the table size with one shared restoring subtract unit.
// ----------------------------------------------------------------------------
module lphi_front
    import lphi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] eff_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KEY_W-1:0]  team_code,
    input  logic [REF_W-1:0]  record_ref,
    input  queue_status_t     q_status,
    output logic              q_push,
    output probe_job_t        q_job
);

    front_state_t         state_reg, state_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     div_reg, div_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIGIT_W-1:0]   digit_reg, digit_next;
    logic [REF_W-1:0]     ref_reg, ref_next;

    logic [REM_W-1:0]     key_val;
    logic [DIGIT_W-1:0]   order;
    logic [REM_W-1:0]     trial;
    logic                 take;
    logic [REM_W-1:0]     rem_sub;
    logic [DIGIT_W-1:0]   digit_upd;

    // Negative keys behave as zero.
    assign key_val = team_code[KEY_W-1] ? '0 : {3'b000, team_code[KEY_W-2:0]};

    always_comb
    begin
        order = '0;
        for (int i = 1; i < 10; i++)
        begin
            if (key_val >= pow10(DIGIT_W'(i)))
            begin
                order = order + 4'd1;
            end
        end
    end

    assign trial     = div_reg << step_reg;
    assign take      = (rem_reg >= trial);
    assign rem_sub   = rem_reg - trial;
    assign digit_upd = digit_reg | (take ? (4'd1 << step_reg[1:0]) : 4'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DIGIT;
                end
            end
            F_DIGIT:
            begin
                if (step_reg == '0)
                begin
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        rem_next   = rem_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        digit_next = digit_reg;
        ref_next   = ref_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = key_val;
                    div_next   = pow10(order);
                    step_next  = DIGIT_TOP;
                    digit_next = '0;
                    ref_next   = record_ref;
                end
            end
            F_DIGIT:
            begin
                digit_next = digit_upd;
                if (take)
                begin
                    rem_next = rem_sub;
                end
                if (step_reg == '0)
                begin
                    rem_next  = REM_W'(digit_upd) + REM_W'(HASH_OFFSET);
                    div_next  = REM_W'(eff_size);
                    step_next = MOD_TOP;
                end
                else
                begin
                    step_next = step_reg - 3'd1;
                end
            end
            F_MOD:
            begin
                if (take)
                begin
                    rem_next = rem_sub;
                end
                if (step_reg != '0)
                begin
                    step_next = step_reg - 3'd1;
                end
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready      = (state_reg == F_IDLE);
    assign q_push        = (state_reg == F_PUSH) && !q_status.full;
    assign q_job.home    = rem_reg[SLOT_W-1:0];
    assign q_job.rec_ref = ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        step_reg  <= step_next;
        digit_reg <= digit_next;
        ref_reg   <= ref_next;
    end

endmodule

[hw/rtl/lphi_queue.sv]
// ----------------------------------------------------------------------------
// lphi_queue
// Two-entry job queue between the hash front end and the probe engine.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_insert_unit_assert.svh"

module lphi_queue
    import lphi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_ctrl_t   ctrl,
    input  probe_job_t    wr_job,
    output probe_job_t    rd_job,
    output queue_status_t status
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    probe_job_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctrl.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign rd_job       = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `LPHI_ASSERT_SAME(a_no_overflow, ctrl.push, !status.full, "job pushed into a full queue")
    `LPHI_ASSERT_SAME(a_no_underflow, ctrl.pop, !status.empty, "job popped from an empty queue")
    `LPHI_ASSERT_SAME(a_ptr_match, status.full || status.empty, wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with fill count")

endmodule

[hw/rtl/lphi_back.sv]
// ----------------------------------------------------------------------------
// lphi_back
// Probe engine: walks the occupancy map 32 slots a cycle from the home slot,
// wraps to slot 0, claims the first free slot and holds the result word.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_insert_unit_assert.svh"

module lphi_back
    import lphi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] eff_size,
    input  queue_status_t     q_status,
    input  probe_job_t        q_job,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output probe_result_t     result
);

    // An 8-bit size never reaches beyond slot 255.
    localparam int unsigned USED     = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int unsigned IDX_W    = $clog2(USED);
    localparam int unsigned NCHUNK   = (USED + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int unsigned CHUNK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int unsigned OCC_BITS = NCHUNK * CHUNK_BITS;
    localparam int unsigned OCC_W    = $clog2(OCC_BITS);

    back_state_t          state_reg, state_next;
    logic [OCC_BITS-1:0]  occ_reg, occ_next;
    logic [REF_W-1:0]     rec_mem [USED];
    logic [SLOT_W-1:0]    home_reg, home_next;
    logic [REF_W-1:0]     ref_reg, ref_next;
    logic                 phase_reg, phase_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    probe_result_t        res_reg, res_next;

    logic [OCC_W-1:0]       chunk_base;
    logic [CHUNK_BITS-1:0]  occ_chunk;
    logic [CHUNK_BITS-1:0]  elig;
    logic [SLOT_W-1:0]      lo_bound;
    logic [SLOT_W-1:0]      hi_bound;
    logic                   hit;
    logic [CHUNK_SEL_W-1:0] hit_j;
    logic [OCC_W-1:0]       hit_idx;
    logic [SLOT_W-1:0]      hit_slot;
    logic [SLOT_W-1:0]      end_chunk;
    logic                   at_end;
    logic                   rec_we;

    assign chunk_base = OCC_W'({chunk_reg, {CHUNK_SEL_W{1'b0}}});
    assign occ_chunk  = occ_reg[chunk_base +: CHUNK_BITS];

    // First pass covers home..size-1, the wrap pass covers 0..home-1.
    assign lo_bound = phase_reg ? '0 : home_reg;
    assign hi_bound = phase_reg ? home_reg : eff_size;

    always_comb
    begin
        for (int j = 0; j < CHUNK_BITS; j++)
        begin
            elig[j] = !occ_chunk[j]
                      && (SLOT_W'({chunk_reg, CHUNK_SEL_W'(j)}) >= lo_bound)
                      && (SLOT_W'({chunk_reg, CHUNK_SEL_W'(j)}) < hi_bound);
        end
    end

    always_comb
    begin
        hit   = 1'b0;
        hit_j = '0;
        for (int j = CHUNK_BITS - 1; j >= 0; j--)
        begin
            if (elig[j])
            begin
                hit   = 1'b1;
                hit_j = CHUNK_SEL_W'(j);
            end
        end
    end

    assign hit_idx   = OCC_W'({chunk_reg, hit_j});
    assign hit_slot  = SLOT_W'({chunk_reg, hit_j});
    assign end_chunk = phase_reg ? ((home_reg - 8'd1) >> CHUNK_SEL_W)
                                 : ((eff_size - 8'd1) >> CHUNK_SEL_W);
    assign at_end    = (SLOT_W'(chunk_reg) == end_chunk);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (hit)
                begin
                    state_next = B_DONE;
                end
                else if (at_end && (phase_reg || (home_reg == '0)))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        occ_next   = occ_reg;
        home_next  = home_reg;
        ref_next   = ref_reg;
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        res_next   = res_reg;
        rec_we     = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    home_next  = q_job.home;
                    ref_next   = q_job.rec_ref;
                    phase_next = 1'b0;
                    chunk_next = CHUNK_W'(q_job.home >> CHUNK_SEL_W);
                end
            end
            B_SCAN:
            begin
                if (hit)
                begin
                    occ_next[hit_idx] = 1'b1;
                    rec_we            = 1'b1;
                    res_next.home     = home_reg;
                    res_next.stored   = hit_slot;
                    res_next.placed   = 1'b1;
                end
                else if (at_end)
                begin
                    if (phase_reg || (home_reg == '0))
                    begin
                        res_next.home   = home_reg;
                        res_next.stored = '0;
                        res_next.placed = 1'b0;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        chunk_next = '0;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            B_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop     = (state_reg == B_IDLE) && !q_status.empty;
    assign out_valid = (state_reg == B_DONE);
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg  <= home_next;
        ref_reg   <= ref_next;
        phase_reg <= phase_next;
        chunk_reg <= chunk_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[hit_slot[IDX_W-1:0]] <= ref_reg;
        end
    end

    `LPHI_ASSERT_SAME(a_home_in_range, q_pop, q_job.home < eff_size, "home slot beyond table size")
    `LPHI_ASSERT_SAME(a_slot_in_range, out_valid && result.placed, result.stored < eff_size, "stored slot beyond table size")
    `LPHI_ASSERT_SAME(a_full_zero_slot, out_valid && !result.placed, result.stored == '0, "unplaced word carries a slot")
    `LPHI_ASSERT_NEXT(a_claim_marks, (state_reg == B_SCAN) && hit, occ_reg[$past(hit_idx)], "claimed slot not marked occupied")

endmodule

[hw/rtl/linear_probe_hash_insert_unit.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_unit
// Each input word is hashed by the front end (accept, 4 digit and 5 modulo steps
// on one subtract unit, push), handed over as a job through the queue, probed in
// one to five 32-slot probe steps at the default depth of 128, and its result word
// presented. The front end takes a new word only once it has pushed the last job.
// Reset clears the occupancy map at once, so the table starts empty and the
// table size returns to 101; no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_unit
    import lphi_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Table size register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,        // table_size[7:0]
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // team_code[31:0], record_ref[47:32]
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // home_slot[6:0], stored_slot[13:7], zero[15:14]
    output logic [0:0]  m_axis_tuser     // placed[0]
);

    // Largest size the table can take: the depth, but never beyond the
    // reach of the 8-bit register.
    localparam logic [SIZE_W-1:0] SIZE_CAP = (TABLE_DEPTH < 256) ? SIZE_W'(TABLE_DEPTH)
                                                                 : 8'd255;

    logic [SIZE_W-1:0] table_size_reg, table_size_next;
    logic [SIZE_W-1:0] eff_size;

    queue_ctrl_t       q_ctrl;
    queue_status_t     q_status;
    probe_job_t        push_job;
    probe_job_t        head_job;
    logic              q_push;
    logic              q_pop;
    probe_result_t     result;

    // The register takes a write whenever one is offered; the user must make writes
    // only while the block is idle, so nothing in flight sees a change; not enforced here.
    assign cfg_ready       = 1'b1;
    assign table_size_next = (cfg_valid && cfg_ready) ? cfg_data : table_size_reg;

    // A size of zero acts as one slot, and a size above the cap is clipped
    // to the cap (the depth, or 255 for deeper tables).
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = 8'd1;
        end
        else if (table_size_reg > SIZE_CAP)
        begin
            eff_size = SIZE_CAP;
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    // The front end hashes one word at a time and hands a job to the queue;
    // it can take the next word while the probe engine is still walking.
    lphi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_size   (eff_size),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .team_code  (s_axis_tdata[31:0]),
        .record_ref (s_axis_tdata[47:32]),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    assign q_ctrl.push = q_push;
    assign q_ctrl.pop  = q_pop;

    lphi_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (q_ctrl),
        .wr_job (push_job),
        .rd_job (head_job),
        .status (q_status)
    );

    // The probe engine holds its result until the downstream side takes it.
    lphi_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_size  (eff_size),
        .q_status  (q_status),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    // Slots are reported in seven bits.
    assign m_axis_tdata = {2'b00, result.stored[OUT_SLOT_W-1:0], result.home[OUT_SLOT_W-1:0]};
    assign m_axis_tuser = result.placed;

endmodule
